>>> rtl/hdec_pkg.sv
package hdec_pkg;

  localparam int unsigned MaxSymbolsDef = 4096;

  localparam int unsigned OpW     = 2;
  localparam int unsigned NodeW   = 12;
  localparam int unsigned LinkW   = 13;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SymW    = 12;
  localparam int unsigned CountW  = 32;
  localparam int unsigned HdrCntW = 3;
  localparam int unsigned BitCntW = 3;

  localparam int unsigned HeaderBytes = 4;

  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_START = 2'd2
  } op_e;

  // one tree node as stored: both child links
  typedef struct packed {
    logic [LinkW-1:0] left;
    logic [LinkW-1:0] right;
  } node_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_node;     // write a tree node
    logic clr_stream;  // start of a new stream
    logic hdr_byte;    // take one count byte
    logic walk_start;  // load the byte, issue the first read
    logic walk_step;   // consume one bit
    logic flush;       // hand the held symbol on as last of byte
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hdr_done;
    logic rem_zero;
    logic leaf;
    logic pend_valid;
    logic out_free;
    logic byte_end;
  } dp_status_t;

endpackage

>>> rtl/hdec_in_if.sv
interface hdec_in_if;
  import hdec_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          operation;
  logic [NodeW-1:0]        node_index;
  logic signed [LinkW-1:0] left_child;
  logic signed [LinkW-1:0] right_child;
  logic [ByteW-1:0]        data_byte;

  modport source (
    output valid, operation, node_index, left_child, right_child, data_byte,
    input  ready
  );

  modport sink (
    input  valid, operation, node_index, left_child, right_child, data_byte,
    output ready
  );
endinterface

>>> rtl/hdec_out_if.sv
interface hdec_out_if;
  import hdec_pkg::*;

  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last;
  logic            stream_done;

  modport source (
    output valid, symbol, last, stream_done,
    input  ready
  );

  modport sink (
    input  valid, symbol, last, stream_done,
    output ready
  );
endinterface

>>> rtl/hdec_ctrl.sv
module hdec_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [hdec_pkg::OpW-1:0] operation_i,
  output logic                   in_ready_o,
  input  hdec_pkg::dp_status_t   status_i,
  output hdec_pkg::ctrl_cmd_t    cmd_o
);
  import hdec_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e state_q;
  logic   accept;
  logic   stall;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // a new leaf must wait when the held one cannot move on
  assign stall = status_i.leaf && status_i.pend_valid && !status_i.out_free;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_LOAD:  cmd_o.wr_node    = 1'b1;
            OP_START: cmd_o.clr_stream = 1'b1;
            OP_BYTE: begin
              if (!status_i.hdr_done) begin
                cmd_o.hdr_byte = 1'b1;
              end else if (!status_i.rem_zero) begin
                cmd_o.walk_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK:  cmd_o.walk_step = !stall;
      ST_FLUSH: cmd_o.flush     = status_i.pend_valid && status_i.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.walk_start) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cmd_o.walk_step && status_i.byte_end) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!status_i.pend_valid || status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/hdec_datapath.sv
module hdec_datapath #(
  parameter int unsigned MAX_SYMBOLS = hdec_pkg::MaxSymbolsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hdec_pkg::ctrl_cmd_t            cmd_i,
  output hdec_pkg::dp_status_t           status_o,
  input  logic [hdec_pkg::NodeW-1:0]     node_index_i,
  input  logic signed [hdec_pkg::LinkW-1:0] left_child_i,
  input  logic signed [hdec_pkg::LinkW-1:0] right_child_i,
  input  logic [hdec_pkg::ByteW-1:0]     data_byte_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [hdec_pkg::SymW-1:0]      symbol_o,
  output logic                           last_o,
  output logic                           stream_done_o
);
  import hdec_pkg::*;

  localparam int unsigned NodeDepth = MAX_SYMBOLS - 1;
  localparam int unsigned AddrW     = (NodeDepth > 1) ? $clog2(NodeDepth) : 1;

  // tree store, one word per internal node
  node_t mem_q [NodeDepth];

  node_t              wr_word;
  logic               wr_en;
  logic               rd_en;
  logic [NodeW-1:0]   rd_node;
  node_t              rd_data_q;
  logic               rd_oob_q;

  logic [NodeW-1:0]   cur_node_q;
  logic [HdrCntW-1:0] hdr_cnt_q;
  logic [CountW-1:0]  rem_q;
  logic [ByteW-1:0]   bits_q;
  logic [BitCntW-1:0] bit_cnt_q;

  logic               pend_valid_q;
  logic [SymW-1:0]    pend_sym_q;
  logic               pend_done_q;

  logic               out_valid_q;
  logic [SymW-1:0]    out_sym_q;
  logic               out_last_q;
  logic               out_done_q;

  logic [LinkW-1:0]   link;
  logic               leaf;
  logic               rem_last;
  logic [NodeW-1:0]   next_node;
  logic               byte_end;
  logic               out_free;
  logic               load_out;

  assign wr_word = {left_child_i, right_child_i};
  assign wr_en   = cmd_i.wr_node && (32'(node_index_i) < NodeDepth);

  // out-of-range nodes read as two root links
  assign link      = rd_oob_q ? '0 : (bits_q[0] ? rd_data_q.right : rd_data_q.left);
  assign leaf      = link[LinkW-1];
  assign next_node = leaf ? '0 : link[NodeW-1:0];
  assign rem_last  = (rem_q == CountW'(1));
  assign byte_end  = (bit_cnt_q == {BitCntW{1'b1}}) || (leaf && rem_last);
  assign out_free  = !out_valid_q || out_ready_i;

  assign rd_en   = cmd_i.walk_start || (cmd_i.walk_step && !byte_end);
  assign rd_node = cmd_i.walk_start ? cur_node_q : next_node;

  // a held symbol moves out when a newer leaf replaces it, or at byte end
  assign load_out = (cmd_i.walk_step && leaf && pend_valid_q) || cmd_i.flush;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AddrW'(node_index_i)] <= wr_word;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[AddrW'(rd_node)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_oob_q <= (32'(rd_node) >= NodeDepth);
    end
    if (cmd_i.walk_start) begin
      bits_q <= data_byte_i;
    end else if (cmd_i.walk_step) begin
      bits_q <= bits_q >> 1;
    end
    if (cmd_i.walk_step && leaf) begin
      pend_sym_q  <= ~link[SymW-1:0];
      pend_done_q <= rem_last;
    end
    if (load_out) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= cmd_i.flush;
      out_done_q <= pend_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_node_q   <= '0;
      hdr_cnt_q    <= '0;
      rem_q        <= '0;
      bit_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_stream) begin
        cur_node_q <= '0;
        hdr_cnt_q  <= '0;
        rem_q      <= '0;
      end
      if (cmd_i.hdr_byte) begin
        rem_q[8*hdr_cnt_q[1:0] +: ByteW] <= data_byte_i;
        hdr_cnt_q                        <= hdr_cnt_q + 1'b1;
      end
      if (cmd_i.walk_start) begin
        bit_cnt_q <= '0;
      end
      if (cmd_i.walk_step) begin
        bit_cnt_q  <= bit_cnt_q + 1'b1;
        cur_node_q <= next_node;
        if (leaf) begin
          rem_q        <= rem_q - 1'b1;
          pend_valid_q <= 1'b1;
        end
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.hdr_done   = (hdr_cnt_q == HdrCntW'(HeaderBytes));
  assign status_o.rem_zero   = (rem_q == '0);
  assign status_o.leaf       = leaf;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;
  assign status_o.byte_end   = byte_end;

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = out_sym_q;
  assign last_o        = out_last_q;
  assign stream_done_o = out_done_q;

endmodule

>>> rtl/huffman_tree_walk_decoder.sv
// Huffman decoder walking a binary code tree held in an on-chip memory of
// MAX_SYMBOLS-1 node words (left and right link, 13 bits each, contents
// undefined until loaded; there is no clearing pass after reset). A data
// byte is walked in steps: accepting it issues the first tree read, then each
// bit is consumed in turn (each bit needs the registered read of the node the
// previous bit chose, so the tree memory's read port paces the walk), and
// last the byte's final symbol is handed to the output register. A byte stops
// early once the symbol count runs out, and is dropped if it was already zero.
// Each symbol is held one step so that its last flag is known when it moves
// to the output register; a stalled output pauses the walk only when a second
// symbol is waiting. Results of one byte come in order, the last one marked.
module huffman_tree_walk_decoder #(
  parameter int unsigned MAX_SYMBOLS = hdec_pkg::MaxSymbolsDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  hdec_in_if.sink   in_i,
  hdec_out_if.source out_o
);
  import hdec_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: input handshake, per-bit stepping, output handoff
  hdec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // tree memory, stream counters, held symbol and output register
  hdec_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .node_index_i  (in_i.node_index),
    .left_child_i  (in_i.left_child),
    .right_child_i (in_i.right_child),
    .data_byte_i   (in_i.data_byte),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .symbol_o      (out_o.symbol),
    .last_o        (out_o.last),
    .stream_done_o (out_o.stream_done)
  );

endmodule

>>> tb/sv/tb_huffman_tree_walk_decoder.sv
module tb_huffman_tree_walk_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hdec_pkg::*;

  // Tree store depth of the default build, and the one opcode the block ignores
  localparam int unsigned      NodeDepth   = MaxSymbolsDef - 1;
  localparam logic [OpW-1:0]   OpUnused    = 2'd3;

  localparam int unsigned PhaseItems  = 65;      // random items per idling phase
  localparam int unsigned HoldCycles  = 300;     // long result-side hold-off
  localparam int unsigned DrainCycles = 24;      // idle time before the final report
  localparam int unsigned CycleLimit  = 400000;  // slowest legal run is well under this

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  // how a directed row gets its expectation
  typedef enum int unsigned {
    ROW_MODEL,  // from the decoder model below
    ROW_QUIET,  // typed in: no symbol at all
    ROW_ONE     // typed in: exactly one symbol
  } row_kind_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [NodeW-1:0] node;
    logic [LinkW-1:0] left;
    logic [LinkW-1:0] right;
    logic [ByteW-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            stream_done;
  } sym_res_t;

  typedef struct {
    in_item_t  item;
    row_kind_e kind;
    sym_res_t  typed;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  hdec_in_if  in_if ();
  hdec_out_if out_if ();

  huffman_tree_walk_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // ---------------------------------------------------------------------------
  // Decoder model: own copy of the tree store and the stream walk state
  // ---------------------------------------------------------------------------
  logic [LinkW-1:0] left_mem  [NodeDepth];
  logic [LinkW-1:0] right_mem [NodeDepth];
  bit               node_written [NodeDepth];
  int unsigned      node_pool [$];       // nodes that are safe to link to
  logic [NodeW-1:0] cur_node;
  int unsigned      hdr_seen;
  logic [31:0]      syms_left;

  sym_res_t item_syms [$];     // symbols caused by the item just decoded
  sym_res_t pending_syms [$];  // symbols still owed by the block, oldest first

  idle_mode_e  idle_mode;
  int unsigned items_sent;
  int unsigned streams;
  int unsigned syms_checked;
  int unsigned errors;
  int unsigned cycle_cnt;
  int unsigned hold_reqs;
  int unsigned holds_done;

  // Walks one accepted item through the model; symbols land in item_syms.
  function automatic void decode_item(in_item_t it);
    logic [LinkW-1:0] link;
    sym_res_t         tail;
    item_syms.delete();
    case (it.op)
      OP_LOAD: begin
        // indexes at or past the store depth are dropped
        if (it.node < NodeDepth) begin
          left_mem[it.node]  = it.left;
          right_mem[it.node] = it.right;
          if (!node_written[it.node]) begin
            node_written[it.node] = 1'b1;
            node_pool.push_back(it.node);
          end
        end
      end
      OP_START: begin
        // tree is kept, only the walk state restarts
        cur_node  = '0;
        hdr_seen  = 0;
        syms_left = '0;
        streams++;
      end
      OP_BYTE: begin
        if (hdr_seen < HeaderBytes) begin
          // little-endian symbol count, no output
          syms_left |= 32'(it.data) << (8 * hdr_seen);
          hdr_seen++;
        end else begin
          // LSB first; rest of the byte is dropped once the count runs out
          for (int unsigned bi = 0; bi < 8 && syms_left != 0; bi++) begin
            if (cur_node >= NodeDepth) begin
              link = '0;
            end else begin
              link = it.data[bi] ? right_mem[cur_node] : left_mem[cur_node];
            end
            if (link[LinkW-1]) begin
              syms_left--;
              item_syms.push_back('{symbol: ~link[SymW-1:0], last: 1'b0,
                                    stream_done: (syms_left == 0)});
              cur_node = '0;
            end else begin
              cur_node = link[NodeW-1:0];
            end
          end
          if (item_syms.size() != 0) begin
            tail = item_syms.pop_back();
            tail.last = 1'b1;
            item_syms.push_back(tail);
          end
        end
      end
      default: ;  // unused opcode: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned src_idle_pct();
    return (idle_mode == IDLE_SRC) ? 56 : (idle_mode == IDLE_BOTH) ? 18 : 0;
  endfunction

  function automatic int unsigned sink_stall_pct();
    return (idle_mode == IDLE_SINK) ? 56 : (idle_mode == IDLE_BOTH) ? 18 : 0;
  endfunction

  // Leaf link for a symbol: -(sym+1) in 13 bits
  function automatic logic [LinkW-1:0] leaf_link(int unsigned sym);
    return {1'b1, ~SymW'(sym)};
  endfunction

  // Random child link. Pointers go only to nodes already written (or the node
  // itself), so the walk can never land on an unwritten entry.
  function automatic logic [LinkW-1:0] rand_link(logic [NodeW-1:0] self_idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return leaf_link(0);
    if (r < 6) return leaf_link(MaxSymbolsDef - 1);
    if (r < 45) return leaf_link($urandom_range(0, MaxSymbolsDef - 1));
    if (r < 58 || node_pool.size() == 0) return LinkW'(self_idx);
    return LinkW'(node_pool[$urandom_range(0, node_pool.size() - 1)]);
  endfunction

  // Random fields everywhere; the block must ignore the ones the op doesn't use
  function automatic in_item_t rand_fields(logic [OpW-1:0] op);
    in_item_t it;
    it.op    = op;
    it.node  = NodeW'($urandom);
    it.left  = LinkW'($urandom);
    it.right = LinkW'($urandom);
    it.data  = ByteW'($urandom);
    return it;
  endfunction

  function automatic dir_row_t mk_row(logic [OpW-1:0] op, int node, int lft, int rgt,
                                      int data, row_kind_e kind = ROW_MODEL,
                                      int sym = 0, bit lst = 1'b0, bit done = 1'b0);
    dir_row_t row;
    row.item  = '{op: op, node: NodeW'(node), left: LinkW'(lft), right: LinkW'(rgt),
                  data: ByteW'(data)};
    row.kind  = kind;
    row.typed = '{symbol: SymW'(sym), last: lst, stream_done: done};
    return row;
  endfunction

  // One input transfer. Drives at the falling edge, waits for the handshake at
  // the rising edge, then books the expectation. Valid stays high afterwards so
  // back-to-back items can follow directly.
  task automatic send_item(input in_item_t it, input row_kind_e kind = ROW_MODEL,
                           input sym_res_t typed = '0);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct()) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= it.op;
    in_if.node_index  <= it.node;
    in_if.left_child  <= it.left;
    in_if.right_child <= it.right;
    in_if.data_byte   <= it.data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_item(it);
    case (kind)
      ROW_MODEL: foreach (item_syms[i]) pending_syms.push_back(item_syms[i]);
      ROW_ONE:   pending_syms.push_back(typed);
      default: ;
    endcase
    if (it.op != OpUnused) items_sent++;
  endtask

  // Drop valid and wait until every owed symbol has come out.
  task automatic drain_symbols();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk_i);
  endtask

  // Writes n nodes; the first one is often the root so tree shapes change.
  task automatic load_batch(int unsigned n);
    in_item_t         it;
    logic [NodeW-1:0] idx;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(0, 1) == 0) begin
        idx = '0;
      end else if (node_pool.size() != 0 && $urandom_range(0, 2) == 0) begin
        idx = NodeW'(node_pool[$urandom_range(0, node_pool.size() - 1)]);
      end else begin
        idx = NodeW'($urandom_range(1, NodeDepth - 1));
      end
      it       = rand_fields(OP_LOAD);
      it.node  = idx;
      it.left  = rand_link(idx);
      it.right = rand_link(idx);
      send_item(it);
    end
  endtask

  // Start item plus the count header; hdr_bytes < 4 leaves a broken header.
  task automatic start_stream(logic [31:0] cnt, int unsigned hdr_bytes);
    in_item_t it;
    send_item(rand_fields(OP_START));
    for (int unsigned i = 0; i < hdr_bytes; i++) begin
      it      = rand_fields(OP_BYTE);
      it.data = cnt[8*i +: 8];
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("[huffman_tree_walk_decoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls per phase, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        // keep ready low long enough for the block to back up into its input
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        holds_done++;
      end
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct());
    end
  end

  // Every accepted symbol is matched against the oldest one owed
  always @(posedge clk_i) begin
    sym_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_syms.size() == 0) begin
        $error("symbol: unexpected transfer, got %0d (last %0b, stream_done %0b)",
               out_if.symbol, out_if.last, out_if.stream_done);
        errors++;
      end else begin
        want = pending_syms.pop_front();
        syms_checked++;
        if (out_if.symbol !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, out_if.symbol);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          errors++;
        end
        if (out_if.stream_done !== want.stream_done) begin
          $error("stream_done: expected %0b, got %0b", want.stream_done,
                 out_if.stream_done);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    dir_tab [$];
    in_item_t    it;
    logic [31:0] cnt;
    int unsigned r;
    int unsigned nbytes;
    int unsigned hdr_cut;
    int unsigned phase_end;

    in_if.valid       = 1'b0;
    in_if.operation   = '0;
    in_if.node_index  = '0;
    in_if.left_child  = '0;
    in_if.right_child = '0;
    in_if.data_byte   = '0;
    rst_ni            = 1'b0;
    idle_mode         = IDLE_NONE;

    // Directed table. Loads, starts and header bytes never produce a symbol,
    // so they are typed in as quiet; walks with several symbols use the model.
    // Root: bit 0 -> symbol 0, bit 1 -> symbol 4095 (both leaf extremes)
    dir_tab.push_back(mk_row(OP_START, 0, 0, 0, 0, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_LOAD, 0, -1, -4096, 0, ROW_QUIET));
    // out-of-range node index: dropped
    dir_tab.push_back(mk_row(OP_LOAD, NodeDepth, -5, -6, 0, ROW_QUIET));
    // unused opcode: no effect
    dir_tab.push_back(mk_row(OpUnused, 5, -2, 3, 8'h5a, ROW_QUIET));
    // count = 1; first bit is 1 -> one symbol 4095, last and done
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h01, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h00, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h00, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h00, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h01, ROW_ONE, 4095, 1'b1, 1'b1));
    // count already reached: byte is dropped
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'hff, ROW_QUIET));
    // zero count: data bytes do nothing
    dir_tab.push_back(mk_row(OP_START, 0, 0, 0, 0, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h00, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h00, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h00, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h00, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'haa, ROW_QUIET));
    // two-level tree through the top node index: 00 -> 7, 01 -> root, 1 -> 4095
    dir_tab.push_back(mk_row(OP_LOAD, NodeDepth - 1, -8, 0, 0, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_LOAD, 0, NodeDepth - 1, -4096, 0, ROW_QUIET));
    // all-ones count header, never runs out
    dir_tab.push_back(mk_row(OP_START, 0, 0, 0, 0, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'hff, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'hff, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'hff, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'hff, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h00));  // four 7s
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'hff));  // eight symbols, the maximum
    // tree rewritten mid-stream: bit 1 now loops on the root
    dir_tab.push_back(mk_row(OP_LOAD, 0, -1, 0, 0, ROW_QUIET));
    dir_tab.push_back(mk_row(OP_BYTE, 0, 0, 0, 8'h0f));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].kind, dir_tab[i].typed);
    drain_symbols();

    // Back-pressure: root gets two leaves so every bit yields a symbol, then
    // the result side holds off while bytes keep coming; the input must stall.
    it       = rand_fields(OP_LOAD);
    it.node  = '0;
    it.left  = leaf_link($urandom_range(0, MaxSymbolsDef - 1));
    it.right = leaf_link($urandom_range(0, MaxSymbolsDef - 1));
    send_item(it);
    hold_reqs++;
    start_stream(32'd500, HeaderBytes);
    repeat (12) send_item(rand_fields(OP_BYTE));
    drain_symbols();

    // Random streams, one idling phase at a time. Mostly well-formed streams
    // with small counts; some zero or huge counts, cut headers, tree rewrites
    // mid-stream and unused opcodes.
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 2) == 0) load_batch($urandom_range(1, 5));
        r = $urandom_range(0, 99);
        if (r < 8) begin
          cnt = '0;
        end else if (r < 16) begin
          cnt = $urandom();
        end else begin
          cnt = $urandom_range(1, 40);
        end
        hdr_cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 3) : HeaderBytes;
        start_stream(cnt, hdr_cut);
        if (hdr_cut == HeaderBytes) begin
          nbytes = $urandom_range(1, 10);
          repeat (nbytes) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
              load_batch(1);
            end else if (r < 12) begin
              send_item(rand_fields(OpUnused));
            end
            send_item(rand_fields(OP_BYTE));
          end
        end
      end
      // sender pauses until the block has caught up
      drain_symbols();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d input transfers over %0d streams and %0d checked symbols,",
             items_sent, streams, syms_checked);
    $display("with idle/stall phases, a long output hold-off and %0d mismatches.", errors);
    if (errors == 0) begin
      $display("[huffman_tree_walk_decoder] OK");
    end else begin
      $display("[huffman_tree_walk_decoder] ERROR");
    end
    $finish;
  end

endmodule
